>>> rtl/dctq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dual-channel time tag qualifier.
// No dependencies; imported by the merge stage and the top level.
package dctq_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LOWER_LIMIT = 1'b0,
    CFG_UPPER_LIMIT = 1'b1
  } cfg_idx_e;

  // Reset values of the delay window, truncated to the delay width at use
  localparam logic [63:0] LOWER_LIMIT_RST = 64'd1;
  localparam logic [63:0] UPPER_LIMIT_RST = 64'd4000000000;

  // Per-request status flags handed from the lanes to the merge stage
  typedef struct packed {
    logic single_channel;
    logic single_mode;
    logic keep_second;
    logic keep_first;
  } dctq_flags_t;

endpackage

>>> rtl/dctq_lane.sv
`timescale 1ns / 1ps
// One qualification lane: holds a channel's last kept (tag, delay) pair and
// its saturating kept and skipped counters. No package dependencies.
module dctq_lane #(
  parameter int unsigned TAG_BITS   = 48,
  parameter int unsigned TIME_BITS  = 40,
  parameter int unsigned COUNT_BITS = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [TAG_BITS-1:0]   tag_i,
  input  logic [TIME_BITS-1:0]  time_i,
  input  logic [TIME_BITS-1:0]  lower_i,
  input  logic [TIME_BITS-1:0]  upper_i,
  output logic                  keep_o,
  output logic [TAG_BITS-1:0]   last_tag_o,
  output logic [TAG_BITS-1:0]   last_tag_d_o,
  output logic [COUNT_BITS-1:0] kept_d_o,
  output logic [COUNT_BITS-1:0] skip_d_o
);

  logic [TAG_BITS-1:0]   tag_q, tag_d;
  logic [TIME_BITS-1:0]  time_q, time_d;
  logic [COUNT_BITS-1:0] kept_q, kept_d;
  logic [COUNT_BITS-1:0] skip_q, skip_d;
  logic                  in_window;
  logic                  is_newer;

  assign in_window = (time_i > lower_i) && (time_i < upper_i);
  assign is_newer  = (tag_i > tag_q) || ((tag_i == tag_q) && (time_i > time_q));
  assign keep_o    = in_window && is_newer;

  always_comb begin
    tag_d  = tag_q;
    time_d = time_q;
    kept_d = kept_q;
    skip_d = skip_q;
    if (en_i) begin
      if (keep_o) begin
        tag_d  = tag_i;
        time_d = time_i;
        // hold at full scale
        if (kept_q != '1) kept_d = kept_q + COUNT_BITS'(1);
      end else begin
        if (skip_q != '1) skip_d = skip_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      time_q <= '0;
      kept_q <= '0;
      skip_q <= '0;
    end else begin
      tag_q  <= tag_d;
      time_q <= time_d;
      kept_q <= kept_d;
      skip_q <= skip_d;
    end
  end

  assign last_tag_o   = tag_q;
  assign last_tag_d_o = tag_d;
  assign kept_d_o     = kept_d;
  assign skip_d_o     = skip_d;

endmodule

>>> rtl/dctq_merge.sv
`timescale 1ns / 1ps
// Merge stage: captures both lanes' results into the output register and
// forms the end tag. Depends on dctq_pkg for the status flag struct.
module dctq_merge import dctq_pkg::*; #(
  parameter int unsigned TAG_BITS   = 48,
  parameter int unsigned COUNT_BITS = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  dctq_flags_t           flags_i,
  input  logic [COUNT_BITS-1:0] kept_one_i,
  input  logic [COUNT_BITS-1:0] kept_two_i,
  input  logic [COUNT_BITS-1:0] skip_one_i,
  input  logic [COUNT_BITS-1:0] skip_two_i,
  input  logic [TAG_BITS-1:0]   tag_one_i,
  input  logic [TAG_BITS-1:0]   tag_two_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // keep_first, keep_second, single_mode, single_channel, kept_count_one,
  // kept_count_two, skipped_count_one, skipped_count_two, end_tag, zero fill
  output logic [((4+4*COUNT_BITS+TAG_BITS+1+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned OUT_BITS = 4 + 4*COUNT_BITS + TAG_BITS + 1;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  logic                  valid_q;
  dctq_flags_t           flags_q;
  logic [COUNT_BITS-1:0] kept_one_q, kept_two_q, skip_one_q, skip_two_q;
  logic [TAG_BITS-1:0]   tag_one_q, tag_two_q;
  logic [TAG_BITS-1:0]   tag_max;
  logic [TAG_BITS:0]     end_tag;
  logic                  load;

  assign ready_o = !valid_q || m_axis_tready;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload holds while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (load) begin
      flags_q    <= flags_i;
      kept_one_q <= kept_one_i;
      kept_two_q <= kept_two_i;
      skip_one_q <= skip_one_i;
      skip_two_q <= skip_two_i;
      tag_one_q  <= tag_one_i;
      tag_two_q  <= tag_two_i;
    end
  end

  assign tag_max = (tag_one_q > tag_two_q) ? tag_one_q : tag_two_q;
  assign end_tag = {1'b0, tag_max} + (TAG_BITS+1)'(1);

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = OUT_W'({end_tag, skip_two_q, skip_one_q, kept_two_q, kept_one_q,
                                 flags_q});

endmodule

>>> rtl/dual_channel_time_tag_qualifier.sv
`timescale 1ns / 1ps
// Dual-channel time tag qualifier, top level.
// Depends on dctq_pkg, dctq_lane (two copies) and dctq_merge.
//
// Usage:
//   s_axis carries one request per record pair: tdata holds the channel 1
//   (or single) tag and delay and the channel 2 tag and delay, tuser holds
//   op (1 = single-channel record). m_axis returns one result per request:
//   keep flags, mode, chosen channel, the four saturating counters and the
//   end tag. The cfg port writes the lower and upper delay limits; write
//   them only while no request is in flight.
//   A request's result is registered in the merge output register and shows
//   on m_axis in the cycle after the request is accepted. Throughput is one
//   request per cycle while the receiver does not stall; the per-record
//   compare against the last kept pair and the counter update are
//   combinational in each lane, and the lanes feed one output register.
//   Reset clears the last kept pairs, the counters and the mode, and loads
//   the limits with 1 and 4000000000 fs.
//   When the receiver stalls, the output register holds its result and
//   s_axis_tready drops until it is taken; a result taken in the same cycle
//   frees the register for the next request.
module dual_channel_time_tag_qualifier import dctq_pkg::*; #(
  parameter int unsigned TAG_BITS   = 48,
  parameter int unsigned TIME_BITS  = 40,
  parameter int unsigned COUNT_BITS = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tag_first, time_first, tag_second, time_second, zero fill
  input  logic [((2*(TAG_BITS+TIME_BITS)+7)/8)*8-1:0] s_axis_tdata,
  // op
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // keep_first, keep_second, single_mode, single_channel, kept_count_one,
  // kept_count_two, skipped_count_one, skipped_count_two, end_tag, zero fill
  output logic [((4+4*COUNT_BITS+TAG_BITS+1+7)/8)*8-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [TIME_BITS-1:0]          cfg_data_i
);

  localparam int unsigned TIME1_LSB = TAG_BITS;
  localparam int unsigned TAG2_LSB  = TAG_BITS + TIME_BITS;
  localparam int unsigned TIME2_LSB = 2*TAG_BITS + TIME_BITS;

  logic [TIME_BITS-1:0] lower_q, upper_q;
  logic                 mode_q, mode_d;
  logic                 chan_q, chan_d;
  logic                 accept;
  logic                 go_single;
  logic                 chan_sel;

  logic [TAG_BITS-1:0]  tag_first, tag_second, tag_lane2;
  logic [TIME_BITS-1:0] time_first, time_second, time_lane2;

  logic                  en_one, en_two;
  logic                  keep_one, keep_two;
  logic [TAG_BITS-1:0]   last_one, last_two, last_one_d, last_two_d;
  logic [COUNT_BITS-1:0] kept_one_d, kept_two_d, skip_one_d, skip_two_d;
  dctq_flags_t           flags;

  assign tag_first   = s_axis_tdata[TAG_BITS-1:0];
  assign time_first  = s_axis_tdata[TIME1_LSB +: TIME_BITS];
  assign tag_second  = s_axis_tdata[TAG2_LSB +: TAG_BITS];
  assign time_second = s_axis_tdata[TIME2_LSB +: TIME_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_LIMIT_RST[TIME_BITS-1:0];
      upper_q <= UPPER_LIMIT_RST[TIME_BITS-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOWER_LIMIT: lower_q <= cfg_data_i;
        CFG_UPPER_LIMIT: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // First single-channel record locks the mode and picks the channel whose
  // last kept tag is lower; equal tags pick channel 1.
  assign go_single = mode_q || s_axis_tuser;
  assign chan_sel  = mode_q ? chan_q : (last_one > last_two);

  always_comb begin
    mode_d = mode_q;
    chan_d = chan_q;
    if (accept && !mode_q && s_axis_tuser) begin
      mode_d = 1'b1;
      chan_d = chan_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      chan_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      chan_q <= chan_d;
    end
  end

  // In single mode only the chosen lane advances, fed from the first record
  assign en_one     = accept && (!go_single || !chan_sel);
  assign en_two     = accept && (!go_single || chan_sel);
  assign tag_lane2  = go_single ? tag_first : tag_second;
  assign time_lane2 = go_single ? time_first : time_second;

  dctq_lane #(
    .TAG_BITS  (TAG_BITS),
    .TIME_BITS (TIME_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_lane_one (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_one),
    .tag_i       (tag_first),
    .time_i      (time_first),
    .lower_i     (lower_q),
    .upper_i     (upper_q),
    .keep_o      (keep_one),
    .last_tag_o  (last_one),
    .last_tag_d_o(last_one_d),
    .kept_d_o    (kept_one_d),
    .skip_d_o    (skip_one_d)
  );

  dctq_lane #(
    .TAG_BITS  (TAG_BITS),
    .TIME_BITS (TIME_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_lane_two (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_two),
    .tag_i       (tag_lane2),
    .time_i      (time_lane2),
    .lower_i     (lower_q),
    .upper_i     (upper_q),
    .keep_o      (keep_two),
    .last_tag_o  (last_two),
    .last_tag_d_o(last_two_d),
    .kept_d_o    (kept_two_d),
    .skip_d_o    (skip_two_d)
  );

  always_comb begin
    flags.keep_first     = (go_single && chan_sel) ? keep_two : keep_one;
    flags.keep_second    = !go_single && keep_two;
    flags.single_mode    = go_single;
    flags.single_channel = go_single && chan_sel;
  end

  dctq_merge #(
    .TAG_BITS  (TAG_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .flags_i      (flags),
    .kept_one_i   (kept_one_d),
    .kept_two_i   (kept_two_d),
    .skip_one_i   (skip_one_d),
    .skip_two_i   (skip_two_d),
    .tag_one_i    (last_one_d),
    .tag_two_i    (last_two_d),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
